>>> sv/wsfd_pkg.sv
// Shared types, codes and helpers of the WebSocket frame deframer.
package wsfd_pkg;

  // Opcode values that the parser distinguishes.
  localparam logic [3:0] OP_CONT  = 4'd0;
  localparam logic [3:0] OP_BIN   = 4'd2;
  localparam logic [3:0] OP_CLOSE = 4'd8;
  localparam logic [3:0] OP_PONG  = 4'd10;

  // Status codes reported with a finished frame.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PROTO   = 2'd1;
  localparam logic [1:0] ST_TOO_BIG = 2'd2;

  // Seven-bit length codes of header byte 1.
  localparam logic [6:0] LEN_MAX_SHORT = 7'd125;
  localparam logic [6:0] LEN_EXT16     = 7'd126;

  // Number of extended length bytes for the 16-bit form.
  localparam logic [2:0] EXT16_BYTES = 3'd2;

  // Reset value of the message size limit.
  localparam logic [31:0] MAX_MSG_RESET = 32'd65536;

  // One result item.
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_done;
    logic [1:0]  status;
    logic [3:0]  frame_opcode;
    logic        final_fragment;
    logic [15:0] close_code;
    logic        close_code_valid;
  } res_t;

  // Data frames are continuation, text and binary.
  function automatic logic is_data_op(input logic [3:0] op);
    return op <= OP_BIN;
  endfunction

  // Known opcodes: data frames plus close, ping and pong.
  function automatic logic is_known_op(input logic [3:0] op);
    return (op <= OP_BIN) || ((op >= OP_CLOSE) && (op <= OP_PONG));
  endfunction

endpackage

>>> sv/websocket_frame_deframer.sv
// WebSocket frame deframer: header parser, payload unmasking and frame reports.
//
//  Channel | Ports                         | Contents
//  --------+-------------------------------+------------------------------------------
//  input   | in_tvalid/in_tready           | tdata: data_byte; tuser: clear_message
//  result  | out_tvalid/out_tready         | tdata: payload byte, status, opcode,
//          |                               |   FIN, close code; tuser: three flags
//  config  | cfg_wr_en, cfg_wr_data        | max_message_bytes
//
// One byte is accepted per cycle when the result side takes results. An accepted
// byte passes the input register, then the parse logic, into the result register.
// rst_n (synchronous, active low) returns the parser to header byte 0, clears
// the message length and loads the size limit with 65536.
// A stalled result side holds the result register and the input register fills
// behind it; in_tready then drops until out_tready returns.
module websocket_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] clear_message
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] payload_byte, [9:8] status,
                                  // [13:10] frame_opcode, [14] final_fragment,
                                  // [30:15] close_code, [31] zero
  output logic [2:0]  out_tuser,  // [0] payload_valid, [1] frame_done,
                                  // [2] close_code_valid
  // Configuration port.
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import wsfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_PAY  = 3'd4,
    PH_HALT = 3'd5
  } phase_t;

  // Pipeline registers.
  logic        s1_vld_r;
  logic [7:0]  s1_byte_r;
  logic        s1_clr_r;
  logic        out_vld_r;
  res_t        out_res_r;
  logic        adv;

  // Configuration and parser state.
  logic [31:0] max_msg_r;
  phase_t      phase_r, phase_nxt;
  logic [2:0]  len_cnt_r, len_cnt_nxt;
  logic [6:0]  short_len_r, short_len_nxt;
  logic [63:0] frame_len_r, frame_len_nxt;
  logic [63:0] left_r, left_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [3:0]  op_r, op_nxt;
  logic        fin_r, fin_nxt;
  logic        mflag_r, mflag_nxt;
  logic [31:0] msg_len_r, msg_len_nxt;
  logic [15:0] close_r, close_nxt;
  logic [1:0]  pay_idx_r, pay_idx_nxt;

  // Parse step helpers.
  res_t        res;
  phase_t      phase_v;
  logic [31:0] msg_len_v;
  logic [7:0]  b;
  logic [7:0]  key_byte;
  logic [7:0]  plain;
  logic [2:0]  cnt_inc;
  logic [1:0]  pos_inc;
  logic [64:0] total_len;
  logic        too_big;
  logic        lk, hc, fn, err;
  logic [1:0]  err_code;

  // Handshake: the input register advances when the result register is free.
  assign adv       = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || adv;

  assign b       = s1_byte_r;
  assign cnt_inc = len_cnt_r + 3'd1;
  assign pos_inc = pos_r + 2'd1;

  // Mask key byte for the current payload position, first key byte first.
  always_comb begin
    unique case (pos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end
  assign plain = b ^ key_byte;

  // Parse one byte: phase work, then length, header and frame completion.
  always_comb begin
    res           = '0;
    phase_nxt     = phase_r;
    len_cnt_nxt   = len_cnt_r;
    short_len_nxt = short_len_r;
    frame_len_nxt = frame_len_r;
    left_nxt      = left_r;
    key_nxt       = key_r;
    pos_nxt       = pos_r;
    op_nxt        = op_r;
    fin_nxt       = fin_r;
    mflag_nxt     = mflag_r;
    close_nxt     = close_r;
    pay_idx_nxt   = pay_idx_r;
    lk            = 1'b0;
    hc            = 1'b0;
    fn            = 1'b0;
    err           = 1'b0;
    err_code      = ST_OK;

    // A clear zeroes the message length and leaves the halt.
    msg_len_v = s1_clr_r ? 32'd0 : msg_len_r;
    phase_v   = (s1_clr_r && (phase_r == PH_HALT)) ? PH_HDR0 : phase_r;
    if (s1_clr_r && (phase_r == PH_HALT)) begin
      phase_nxt = PH_HDR0;
    end
    msg_len_nxt = msg_len_v;

    unique case (phase_v)
      PH_HALT: begin
      end
      PH_HDR1: begin
        mflag_nxt     = b[7];
        short_len_nxt = b[6:0];
        len_cnt_nxt   = 3'd0;
        if (b[6:0] <= LEN_MAX_SHORT) begin
          frame_len_nxt = {57'd0, b[6:0]};
          lk            = 1'b1;
        end else begin
          frame_len_nxt = 64'd0;
          phase_nxt     = PH_EXT;
        end
      end
      PH_EXT: begin
        frame_len_nxt = {frame_len_r[55:0], b};
        len_cnt_nxt   = cnt_inc;
        if (((short_len_r == LEN_EXT16) && (cnt_inc == EXT16_BYTES)) ||
            ((short_len_r != LEN_EXT16) && (cnt_inc == 3'd0))) begin
          lk = 1'b1;
        end
      end
      PH_MASK: begin
        key_nxt = {key_r[23:0], b};
        pos_nxt = pos_inc;
        if (pos_inc == 2'd0) begin
          hc = 1'b1;
        end
      end
      PH_PAY: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = plain;
        pos_nxt           = pos_inc;
        if (pay_idx_r < 2'd2) begin
          close_nxt   = {close_r[7:0], plain};
          pay_idx_nxt = pay_idx_r + 2'd1;
        end
        left_nxt = left_r - 64'd1;
        if (left_r == 64'd1) begin
          fn = 1'b1;
        end
      end
      default: begin
        fin_nxt   = b[7];
        op_nxt    = b[3:0];
        phase_nxt = PH_HDR1;
      end
    endcase

    // Size check against the limit: frame length plus message length, no wrap.
    total_len = {1'b0, frame_len_nxt} + {33'd0, msg_len_v};
    too_big   = total_len > {33'd0, max_msg_r};

    // Length known: control frame and size checks, then mask or header end.
    if (lk) begin
      if (!is_data_op(op_r) && (short_len_nxt > LEN_MAX_SHORT)) begin
        err      = 1'b1;
        err_code = ST_PROTO;
      end else if (too_big) begin
        err      = 1'b1;
        err_code = ST_TOO_BIG;
      end else begin
        key_nxt = 32'd0;
        pos_nxt = 2'd0;
        if (mflag_nxt) begin
          phase_nxt = PH_MASK;
        end else begin
          hc = 1'b1;
        end
      end
    end

    // Header complete: pending message check, message accounting.
    if (hc) begin
      if (is_data_op(op_r) && (frame_len_nxt != 64'd0) && (msg_len_v != 32'd0) &&
          (op_r != OP_CONT)) begin
        err      = 1'b1;
        err_code = ST_PROTO;
      end else begin
        if (is_data_op(op_r)) begin
          msg_len_nxt = msg_len_v + frame_len_nxt[31:0];
        end
        pos_nxt     = 2'd0;
        close_nxt   = 16'd0;
        pay_idx_nxt = 2'd0;
        if (frame_len_nxt == 64'd0) begin
          fn = 1'b1;
        end else begin
          left_nxt  = frame_len_nxt;
          phase_nxt = PH_PAY;
        end
      end
    end

    // Frame finished: report it, or flag an unknown opcode.
    if (fn) begin
      if (!is_known_op(op_r)) begin
        err      = 1'b1;
        err_code = ST_PROTO;
      end else begin
        res.frame_done     = 1'b1;
        res.frame_opcode   = op_r;
        res.final_fragment = fin_r;
        if ((op_r == OP_CLOSE) && (frame_len_nxt[63:1] != 63'd0)) begin
          res.close_code       = close_nxt;
          res.close_code_valid = 1'b1;
        end
        phase_nxt = PH_HDR0;
      end
    end

    // Errors report the held header and halt the parser.
    if (err) begin
      res.frame_done     = 1'b1;
      res.status         = err_code;
      res.frame_opcode   = op_r;
      res.final_fragment = fin_r;
      phase_nxt          = PH_HALT;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_msg_r <= MAX_MSG_RESET;
    end else if (cfg_wr_en) begin
      max_msg_r <= cfg_wr_data;
    end
  end

  // Pipeline valid flags and parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      phase_r     <= PH_HDR0;
      len_cnt_r   <= 3'd0;
      short_len_r <= 7'd0;
      frame_len_r <= 64'd0;
      left_r      <= 64'd0;
      key_r       <= 32'd0;
      pos_r       <= 2'd0;
      op_r        <= 4'd0;
      fin_r       <= 1'b0;
      mflag_r     <= 1'b0;
      msg_len_r   <= 32'd0;
      close_r     <= 16'd0;
      pay_idx_r   <= 2'd0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_vld_r <= 1'b1;
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r   <= 1'b1;
        phase_r     <= phase_nxt;
        len_cnt_r   <= len_cnt_nxt;
        short_len_r <= short_len_nxt;
        frame_len_r <= frame_len_nxt;
        left_r      <= left_nxt;
        key_r       <= key_nxt;
        pos_r       <= pos_nxt;
        op_r        <= op_nxt;
        fin_r       <= fin_nxt;
        mflag_r     <= mflag_nxt;
        msg_len_r   <= msg_len_nxt;
        close_r     <= close_nxt;
        pay_idx_r   <= pay_idx_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_clr_r  <= in_tuser;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  // Result ports.
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_res_r.close_code, out_res_r.final_fragment,
                       out_res_r.frame_opcode, out_res_r.status, out_res_r.payload_byte};
  assign out_tuser  = {out_res_r.close_code_valid, out_res_r.frame_done,
                       out_res_r.payload_valid};

  // An error report always comes with frame completion.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_res_r.status != ST_OK)) |-> out_res_r.frame_done)
    else $error("error status without frame_done");

  // A close code is only reported for a clean close frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.close_code_valid) |->
      (out_res_r.frame_done && (out_res_r.status == ST_OK) &&
       (out_res_r.frame_opcode == OP_CLOSE)))
    else $error("close code reported outside a clean close frame");

  // Any error result leaves the parser halted.
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (res.status != ST_OK)) |=> (phase_r == PH_HALT))
    else $error("parser not halted after an error");

endmodule
